@@ rtl/vcsd_pkg.sv @@
// Shared types and constants for the voxel column span decoder.
`timescale 1ns / 1ps
package vcsd_pkg;
   localparam int COLUMN_HEIGHT = 64;
   localparam int DEPTH_W = 6;
   localparam int MAP_SIDE = 512;
   localparam int COORD_W = 9;

   typedef enum logic [1:0] {
      OP_COLOUR = 2'd0,
      OP_HEADER = 2'd1
   } op_type;

   // One assembled group of four bytes passed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [7:0]  chunk_count;
      logic [7:0]  top_begin;
      logic [7:0]  top_end;
      logic [7:0]  air_start;
      logic [23:0] colour;
   } cmd_type;
endpackage

@@ rtl/vcsd_front.sv @@
// Front part: groups bytes into headers and colours and tracks the span phase.
`timescale 1ns / 1ps
module vcsd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output vcsd_pkg::cmd_type  cmd_data
);
   logic [1:0]  slot_ff;
   logic        in_colours_ff;
   logic [7:0]  chunk_ff, ts_ff, te_ff;
   logic [8:0]  left_ff;
   logic [23:0] col_ff;
   logic [8:0]  top_cnt;
   logic [8:0]  left_in;
   logic        fire, last;

   assign req_ready = cmd_ready;
   assign fire = req_valid && req_ready;
   assign last = (slot_ff == 2'd3);
   assign cmd_valid = req_valid && last;
   assign top_cnt = (te_ff >= ts_ff) ? ({1'b0, te_ff} - {1'b0, ts_ff} + 9'd1) : 9'd0;
   assign left_in = (chunk_ff != 8'd0) ? ({1'b0, chunk_ff} - 9'd1) : top_cnt;

   always_comb begin
      cmd_data.op = in_colours_ff ? vcsd_pkg::OP_COLOUR : vcsd_pkg::OP_HEADER;
      cmd_data.chunk_count = chunk_ff;
      cmd_data.top_begin = ts_ff;
      cmd_data.top_end = te_ff;
      cmd_data.air_start = req_data_byte;
      cmd_data.colour = col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
         in_colours_ff <= 1'b0;
         left_ff <= 9'd0;
      end else if (fire) begin
         slot_ff <= slot_ff + 2'd1;
         if (in_colours_ff) begin
            unique case (slot_ff)
               2'd0: col_ff[7:0] <= req_data_byte;
               2'd1: col_ff[15:8] <= req_data_byte;
               2'd2: col_ff[23:16] <= req_data_byte;
               default: begin
                  left_ff <= left_ff - 9'd1;
                  if (left_ff == 9'd1) in_colours_ff <= 1'b0;
               end
            endcase
         end else begin
            unique case (slot_ff)
               2'd0: chunk_ff <= req_data_byte;
               2'd1: ts_ff <= req_data_byte;
               2'd2: te_ff <= req_data_byte;
               default: begin
                  left_ff <= left_in;
                  in_colours_ff <= (left_in != 9'd0);
               end
            endcase
         end
      end
   end
endmodule

@@ rtl/vcsd_queue.sv @@
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module vcsd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  vcsd_pkg::cmd_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output vcsd_pkg::cmd_type  out_data
);
   vcsd_pkg::cmd_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule

@@ rtl/vcsd_back.sv @@
// Back part: updates the column store, places bottom colours and emits columns.
`timescale 1ns / 1ps
module vcsd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  vcsd_pkg::cmd_type  cmd_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_voxel_depth,
   output logic               rsp_solid,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [8:0]         rsp_column_x,
   output logic [8:0]         rsp_column_y,
   output logic               rsp_last_of_column,
   output logic               rsp_last_of_map,
   output logic               rsp_format_error
);
   typedef enum logic [2:0] {
      S_IDLE, S_PLACE, S_PUT, S_CLEAR, S_READ, S_EMIT, S_RESET
   } state_type;

   localparam logic [8:0] LastCoord = 9'(vcsd_pkg::MAP_SIDE - 1);
   localparam logic [24:0] SolidBlack = 25'h1000000;

   state_type   state_ff;
   logic [24:0] store_ff [vcsd_pkg::COLUMN_HEIGHT];
   logic [23:0] bottom_ff [vcsd_pkg::COLUMN_HEIGHT];
   logic        first_ff, err_ff, emit_after_ff;
   logic [7:0]  chunk_ff, ts_ff, te_ff;
   logic [8:0]  top_cnt_ff, idx_ff, left_ff, pend_ff;
   logic [8:0]  walk_ff;
   logic [9:0]  pos_ff;
   logic [8:0]  cx_ff, cy_ff;
   logic [24:0] rdata_ff;
   logic [23:0] bdata_ff;
   logic [8:0]  new_top_cnt, new_left;
   logic [9:0]  tdepth;
   logic [9:0]  bidx;

   assign cmd_ready = (state_ff == S_IDLE);
   assign new_top_cnt = (cmd_data.top_end >= cmd_data.top_begin) ?
      ({1'b0, cmd_data.top_end} - {1'b0, cmd_data.top_begin} + 9'd1) : 9'd0;
   assign new_left = (cmd_data.chunk_count != 8'd0) ?
      ({1'b0, cmd_data.chunk_count} - 9'd1) : new_top_cnt;
   assign tdepth = {2'b0, ts_ff} + {1'b0, idx_ff};
   assign bidx = {1'b0, idx_ff} - {1'b0, top_cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RESET;
         rsp_valid <= 1'b0;
         cx_ff <= 9'd0;
         cy_ff <= 9'd0;
         walk_ff <= 9'd0;
         first_ff <= 1'b1;
         err_ff <= 1'b0;
         pend_ff <= 9'd0;
      end else begin
         unique case (state_ff)
            S_RESET: begin
               // One store entry per cycle is made solid and black after reset.
               store_ff[walk_ff[5:0]] <= SolidBlack;
               walk_ff <= walk_ff + 9'd1;
               if (walk_ff == 9'(vcsd_pkg::COLUMN_HEIGHT - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (cmd_valid) begin
               if (cmd_data.op == vcsd_pkg::OP_HEADER) begin
                  chunk_ff <= cmd_data.chunk_count;
                  ts_ff <= cmd_data.top_begin;
                  te_ff <= cmd_data.top_end;
                  top_cnt_ff <= new_top_cnt;
                  left_ff <= new_left;
                  idx_ff <= 9'd0;
                  emit_after_ff <= (cmd_data.chunk_count == 8'd0) && (new_left == 9'd0);
                  if (first_ff) begin
                     pos_ff <= 10'd0;
                     state_ff <= S_CLEAR;
                  end else begin
                     // Bottom colours end just above the new air start.
                     pos_ff <= {2'b0, cmd_data.air_start} - {1'b0, pend_ff};
                     walk_ff <= 9'd0;
                     state_ff <= S_PLACE;
                  end
                  first_ff <= 1'b0;
               end else begin
                  if (idx_ff < top_cnt_ff) begin
                     if (tdepth < 10'(vcsd_pkg::COLUMN_HEIGHT))
                        store_ff[tdepth[5:0]] <= {1'b1, cmd_data.colour};
                     else err_ff <= 1'b1;
                  end else if (bidx < 10'(vcsd_pkg::COLUMN_HEIGHT)) begin
                     bottom_ff[bidx[5:0]] <= cmd_data.colour;
                  end
                  idx_ff <= idx_ff + 9'd1;
                  left_ff <= left_ff - 9'd1;
                  if (left_ff == 9'd1) begin
                     pend_ff <= (idx_ff + 9'd1 > top_cnt_ff) ?
                        (idx_ff + 9'd1 - top_cnt_ff) : 9'd0;
                     if (chunk_ff == 8'd0) begin
                        walk_ff <= 9'd0;
                        state_ff <= S_READ;
                     end
                  end
               end
            end
            S_PLACE: begin
               if (walk_ff == pend_ff) begin
                  state_ff <= S_CLEAR;
               end else begin
                  bdata_ff <= bottom_ff[walk_ff[5:0]];
                  state_ff <= S_PUT;
               end
            end
            S_PUT: begin
               if (walk_ff >= 9'(vcsd_pkg::COLUMN_HEIGHT) || pos_ff[9] ||
                   pos_ff >= 10'(vcsd_pkg::COLUMN_HEIGHT))
                  err_ff <= 1'b1;
               else
                  store_ff[pos_ff[5:0]] <= {1'b1, bdata_ff};
               pos_ff <= pos_ff + 10'd1;
               walk_ff <= walk_ff + 9'd1;
               state_ff <= S_PLACE;
            end
            S_CLEAR: begin
               // pos_ff is zero or the air start; clear up to the top colour start.
               if (pos_ff[9] || pos_ff >= {2'b0, ts_ff}) begin
                  pend_ff <= 9'd0;
                  if (emit_after_ff) begin
                     walk_ff <= 9'd0;
                     state_ff <= S_READ;
                  end else state_ff <= S_IDLE;
               end else begin
                  if (pos_ff < 10'(vcsd_pkg::COLUMN_HEIGHT)) store_ff[pos_ff[5:0]] <= 25'd0;
                  else err_ff <= 1'b1;
                  pos_ff <= pos_ff + 10'd1;
               end
            end
            S_READ: begin
               // Each entry is read out and left solid and black for the next column.
               rdata_ff <= store_ff[walk_ff[5:0]];
               store_ff[walk_ff[5:0]] <= SolidBlack;
               state_ff <= S_EMIT;
            end
            S_EMIT: if (!rsp_valid || rsp_ready) begin
               rsp_valid <= 1'b1;
               rsp_voxel_depth <= walk_ff[5:0];
               rsp_solid <= rdata_ff[24];
               rsp_red <= rdata_ff[23:16];
               rsp_green <= rdata_ff[15:8];
               rsp_blue <= rdata_ff[7:0];
               rsp_column_x <= cx_ff;
               rsp_column_y <= cy_ff;
               rsp_last_of_column <= (walk_ff == 9'(vcsd_pkg::COLUMN_HEIGHT - 1));
               rsp_last_of_map <= (walk_ff == 9'(vcsd_pkg::COLUMN_HEIGHT - 1)) &&
                  (cx_ff == LastCoord) && (cy_ff == LastCoord);
               rsp_format_error <= err_ff;
               walk_ff <= walk_ff + 9'd1;
               if (walk_ff == 9'(vcsd_pkg::COLUMN_HEIGHT - 1)) begin
                  if (cx_ff == LastCoord) begin
                     cx_ff <= 9'd0;
                     cy_ff <= cy_ff + 9'd1;
                  end else cx_ff <= cx_ff + 9'd1;
                  first_ff <= 1'b1;
                  err_ff <= 1'b0;
                  pend_ff <= 9'd0;
                  state_ff <= S_IDLE;
               end else state_ff <= S_READ;
            end
            default: state_ff <= S_RESET;
         endcase
         if (state_ff != S_EMIT && rsp_ready) rsp_valid <= 1'b0;
      end
   end
endmodule

@@ rtl/vxl_column_span_decoder_core.sv @@
// Top level of the voxel column span decoder.
// A group of four bytes passes from the front part through the two-entry queue to the back part,
// which stores a colour and handles a header by placing pending bottom colours and clearing depths.
// A finished column emits 64 items.
// Throughput: one byte per cycle while the two-entry queue has room; the back part's work
// sets the sustained rate. Reset is synchronous; afterwards a pass over the column store
// makes it solid and black before the first group is processed.
`timescale 1ns / 1ps
module vxl_column_span_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_voxel_depth,
   output logic       rsp_solid,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic [8:0] rsp_column_x,
   output logic [8:0] rsp_column_y,
   output logic       rsp_last_of_column,
   output logic       rsp_last_of_map,
   output logic       rsp_format_error
);
   logic f_valid, f_ready, b_valid, b_ready;
   vcsd_pkg::cmd_type f_data, b_data;

   vcsd_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   vcsd_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   vcsd_back u_back (
      .clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_voxel_depth, .rsp_solid, .rsp_red, .rsp_green,
      .rsp_blue, .rsp_column_x, .rsp_column_y, .rsp_last_of_column,
      .rsp_last_of_map, .rsp_format_error
   );
endmodule

@@ tb/vxl_column_span_decoder_core_tb.sv @@
// Self-checking testbench for the voxel column span decoder core.
`timescale 1ns / 1ps
module vxl_column_span_decoder_core_tb;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int MAX_IDLE = 17;

   typedef struct packed {
      logic [5:0] depth;
      logic       solid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [8:0] col_x;
      logic [8:0] col_y;
      logic       last_col;
      logic       last_map;
      logic       err;
   } voxel_type;

   typedef struct {
      logic [7:0] data;
      bit         drain;
   } file_byte_type;

   typedef enum int {SPAN_FIRST, SPAN_NEXT, SPAN_COLOURS} span_phase_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [7:0] req_data_byte = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [5:0] rsp_voxel_depth;
   logic       rsp_solid;
   logic [7:0] rsp_red, rsp_green, rsp_blue;
   logic [8:0] rsp_column_x, rsp_column_y;
   logic       rsp_last_of_column, rsp_last_of_map, rsp_format_error;

   vxl_column_span_decoder_core DUT (.*);

   always #6 clock = ~clock;

   file_byte_type  file_bytes[$];
   voxel_type      voxels_due[$];
   int          errors = 0;
   bit          req_took, rsp_took;
   int          bytes_sent = 0, voxels_seen = 0;
   int          send_gap = 0, recv_stall = 0, idle_cycles = 0;

   // Decoder state mirrored from the span format.
   span_phase_type phase;
   int          slot, chunks, top_first, top_last, cursor, colours_left;
   int          bottom_count, colour_idx, top_len;
   logic [23:0] colour_acc;
   logic [24:0] column[vcsd_pkg::COLUMN_HEIGHT];
   logic [23:0] bottoms[vcsd_pkg::COLUMN_HEIGHT];
   int          col_x, col_y;
   bit          col_err;

   function automatic void clear_column();
      for (int d = 0; d < vcsd_pkg::COLUMN_HEIGHT; d++) column[d] = 25'h1000000;
      phase = SPAN_FIRST;
      cursor = 0;
      bottom_count = 0;
      col_err = 0;
   endfunction

   function automatic void paint(int depth, logic [23:0] c);
      if (depth < 0 || depth >= vcsd_pkg::COLUMN_HEIGHT) col_err = 1;
      else column[depth] = {1'b1, c};
   endfunction

   function automatic void emit_voxels();
      voxel_type v;
      bit map_end;
      map_end = (col_x == vcsd_pkg::MAP_SIDE - 1) && (col_y == vcsd_pkg::MAP_SIDE - 1);
      for (int d = 0; d < vcsd_pkg::COLUMN_HEIGHT; d++) begin
         v.depth = d[5:0];
         v.solid = column[d][24];
         v.red = column[d][23:16];
         v.green = column[d][15:8];
         v.blue = column[d][7:0];
         v.col_x = col_x[8:0];
         v.col_y = col_y[8:0];
         v.last_col = (d == vcsd_pkg::COLUMN_HEIGHT - 1);
         v.last_map = v.last_col && map_end;
         v.err = col_err;
         voxels_due.push_back(v);
      end
      col_x++;
      if (col_x >= vcsd_pkg::MAP_SIDE) begin
         col_x = 0;
         col_y++;
         if (col_y >= vcsd_pkg::MAP_SIDE) col_y = 0;
      end
      clear_column();
   endfunction

   function automatic void finish_header(int air_start);
      int base;
      if (phase == SPAN_NEXT) begin
         base = air_start - bottom_count;
         for (int i = 0; i < bottom_count; i++) begin
            if (i < vcsd_pkg::COLUMN_HEIGHT) paint(base + i, bottoms[i]);
            else col_err = 1;
         end
         cursor = air_start;
      end
      for (int i = cursor; i < top_first; i++) begin
         if (i < vcsd_pkg::COLUMN_HEIGHT) column[i] = '0;
         else col_err = 1;
      end
      top_len = (top_last >= top_first) ? top_last - top_first + 1 : 0;
      colours_left = (chunks != 0) ? chunks - 1 : top_len;
      colour_idx = 0;
      bottom_count = 0;
      if (colours_left == 0) begin
         if (chunks == 0) emit_voxels();
         else phase = SPAN_NEXT;
      end else begin
         phase = SPAN_COLOURS;
      end
   endfunction

   function automatic void finish_colour();
      if (colour_idx < top_len) paint(top_first + colour_idx, colour_acc);
      else if (colour_idx - top_len < vcsd_pkg::COLUMN_HEIGHT)
         bottoms[colour_idx - top_len] = colour_acc;
      colour_idx++;
      colours_left--;
      if (colours_left != 0) return;
      if (chunks == 0) begin
         emit_voxels();
         return;
      end
      bottom_count = (colour_idx > top_len) ? colour_idx - top_len : 0;
      phase = SPAN_NEXT;
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      int s;
      s = slot;
      slot = (slot + 1) % 4;
      if (phase == SPAN_COLOURS) begin
         case (s)
            0: colour_acc = {16'h0, b};
            1: colour_acc[15:8] = b;
            2: colour_acc[23:16] = b;
            default: finish_colour();
         endcase
      end else begin
         case (s)
            0: chunks = b;
            1: top_first = b;
            2: top_last = b;
            default: finish_header(b);
         endcase
      end
   endfunction

   // Stimulus helpers.
   task automatic put_byte(int b, bit drain = 0);
      file_byte_type f;
      f.data = b[7:0];
      f.drain = drain;
      file_bytes.push_back(f);
   endtask

   task automatic put_span(int cnt, int ts, int te, int air, int ncol, bit drain = 0);
      put_byte(cnt, drain);
      put_byte(ts);
      put_byte(te);
      put_byte(air);
      for (int i = 0; i < 4 * ncol; i++) put_byte($urandom_range(0, 255));
   endtask

   // A column of random spans; rough occasionally pushes depths out of the column.
   task automatic put_column(bit rough, bit drain);
      int spans, ts, te, tc, bc, air, cnt, ncol;
      spans = $urandom_range(0, 3);
      air = 0;
      for (int s = 0; s <= spans; s++) begin
         ts = rough ? $urandom_range(0, 80) : air + $urandom_range(0, 8);
         if (ts > 63 && !rough) ts = 63;
         te = ($urandom_range(0, 7) == 0) ? ts - 1 : ts + $urandom_range(0, 5);
         if (te > 63 && !rough) te = 63;
         tc = (te >= ts) ? te - ts + 1 : 0;
         if (s == spans) begin
            put_span(0, ts, te, air, tc, drain);
         end else begin
            bc = $urandom_range(0, 3);
            cnt = tc + bc + 1;
            if ($urandom_range(0, 5) == 0) cnt = $urandom_range(1, cnt);
            ncol = cnt - 1;
            put_span(cnt, ts, te, air, ncol, drain);
            air = (te + 1 + bc + $urandom_range(0, 6)) % 64;
            if (rough) air = $urandom_range(0, 255);
         end
         drain = 0;
      end
   endtask

   initial begin
      slot = 0;
      chunks = 0;
      top_first = 0;
      top_last = 0;
      colours_left = 0;
      colour_idx = 0;
      top_len = 0;
      colour_acc = '0;
      col_x = 0;
      col_y = 0;
      for (int d = 0; d < vcsd_pkg::COLUMN_HEIGHT; d++) bottoms[d] = '0;
      clear_column();

      // Directed columns: reversed top run, extreme bytes, short span, deep clear,
      // bottom colours placed by the next air start.
      put_span(0, 5, 2, 0, 0);
      put_byte(0); put_byte(0); put_byte(0); put_byte(255);
      put_byte(255); put_byte(255); put_byte(255); put_byte(255);
      put_span(2, 62, 66, 0, 1);
      put_span(0, 255, 0, 10, 0);
      put_span(3, 1, 1, 0, 2);
      put_span(0, 20, 19, 5, 0);

      // The sender holds the first random item until the directed voxels are back.
      put_column(0, 1);
      while (file_bytes.size() < 330) begin
         put_column($urandom_range(0, 4) == 0, file_bytes.size() > 200 &&
                    file_bytes.size() < 240);
      end

      repeat (6) @(negedge clock);
      reset <= 0;
      wait (file_bytes.size() == 0 && !req_valid && voxels_due.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("vxl_column_span_decoder_core verification clean");
      else $display("vxl_column_span_decoder_core verification failed");
      $finish;
   end

   // Acceptance, prediction and checking on the rising edge.
   always @(posedge clock) begin
      voxel_type got, want;
      req_took = req_valid && req_ready && !reset;
      rsp_took = rsp_valid && rsp_ready && !reset;
      if (rsp_took) begin
         got = {rsp_voxel_depth, rsp_solid, rsp_red, rsp_green, rsp_blue, rsp_column_x,
                rsp_column_y, rsp_last_of_column, rsp_last_of_map, rsp_format_error};
         voxels_seen++;
         if (voxels_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected voxel %h", $time, got);
         end else begin
            want = voxels_due.pop_front();
            if (got.depth !== want.depth || got.solid !== want.solid ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.col_x !== want.col_x ||
                got.col_y !== want.col_y || got.last_col !== want.last_col ||
                got.last_map !== want.last_map || got.err !== want.err) begin
               errors++;
               $display("%0t: voxel mismatch expected %h actual %h", $time, want, got);
            end
         end
      end
      if (req_took) decode_byte(req_data_byte);
      idle_cycles = (req_took || rsp_took) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("vxl_column_span_decoder_core verification failed");
         $finish;
      end
   end

   // Byte driver: stretches without gaps alternate with random gaps.
   always @(negedge clock) begin
      file_byte_type f;
      bit next_valid;
      if (!reset && (!req_valid || req_took)) begin
         next_valid = 0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (file_bytes.size() > 0 &&
                      !(file_bytes[0].drain && voxels_due.size() > 0)) begin
            f = file_bytes.pop_front();
            req_data_byte <= f.data;
            next_valid = 1;
            bytes_sent++;
            send_gap = ((bytes_sent / 60) % 4 == 0) ? 0 : $urandom_range(0, MAX_IDLE);
         end
         req_valid <= next_valid;
      end
   end

   // Voxel receiver stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took)
            recv_stall = ((voxels_seen / 100) % 3 == 0) ? 0 : $urandom_range(0, MAX_IDLE);
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end
endmodule

@@ sim.f @@
rtl/vcsd_pkg.sv
rtl/vcsd_front.sv
rtl/vcsd_queue.sv
rtl/vcsd_back.sv
rtl/vxl_column_span_decoder_core.sv
tb/vxl_column_span_decoder_core_tb.sv
